/* rtl/sbm_pkg.sv */
// shared types and constants of the stereo block matcher
package sbm_pkg;

  // fixed field widths
  localparam int PIX_W    = 8;
  localparam int CNT_W    = 12;
  localparam int RING_W   = 4;
  localparam int HALF_W   = 2;
  localparam int COORD_W  = 10;
  localparam int CFG_W    = 11;
  localparam int ROW_LIMIT = 1024;
  localparam int QUEUE_DEPTH = 2;

  // parameter defaults
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_WINDOW = 7;
  localparam int DEF_LINE_ROWS  = 8;

  // register reset values
  localparam logic [CFG_W-1:0] RST_WIDTH  = 11'd640;
  localparam logic [CFG_W-1:0] RST_HEIGHT = 11'd480;
  localparam logic [2:0]       RST_WINDOW = 3'd5;

  // register indexes
  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_WINDOW = 2'd2
  } cfg_idx_e;

  // classified item handed from front to back
  typedef struct packed {
    logic [PIX_W-1:0]   left_pix;
    logic [PIX_W-1:0]   right_pix;
    logic [CNT_W-1:0]   col;
    logic [CNT_W-1:0]   width;
    logic [RING_W-1:0]  ring;
    logic [HALF_W-1:0]  half;
    logic               valid;
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
  } cmd_t;

  // result item
  typedef struct packed {
    logic               valid_res;
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
    logic [COORD_W-1:0] disparity;
  } res_t;

endpackage

/* rtl/sbm_if.sv */
// stream interfaces for pixel pairs and disparity results
interface sbm_in_if;
  logic       valid;
  logic       ready;
  logic       frame_start;
  logic [7:0] left_pixel;
  logic [7:0] right_pixel;
  modport source (output valid, frame_start, left_pixel, right_pixel, input ready);
  modport sink   (input valid, frame_start, left_pixel, right_pixel, output ready);
endinterface

interface sbm_out_if;
  logic       valid;
  logic       ready;
  logic       valid_res;
  logic [9:0] out_row;
  logic [9:0] out_col;
  logic [9:0] disparity;
  modport source (output valid, valid_res, out_row, out_col, disparity, input ready);
  modport sink   (input valid, valid_res, out_row, out_col, disparity, output ready);
endinterface

/* rtl/sbm_ram.sv */
// generic single write port ram with registered read
module sbm_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [W-1:0]             wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [W-1:0]             rdata_o
);
  logic [W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* rtl/sbm_fifo.sv */
// short command queue between front and back
module sbm_fifo import sbm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t data_o,
  output logic empty_o
);
  localparam int AW = $clog2(QUEUE_DEPTH);

  cmd_t            mem_q [QUEUE_DEPTH];
  logic [AW-1:0]   wr_q, rd_q;
  logic [AW:0]     cnt_q;

  assign full_o  = (cnt_q == (AW+1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == AW'(QUEUE_DEPTH-1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == AW'(QUEUE_DEPTH-1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end
endmodule

/* rtl/sbm_front.sv */
// front end: raster counters and edge classification of each item
module sbm_front import sbm_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_WINDOW = DEF_MAX_WINDOW,
  parameter int LINE_ROWS  = DEF_LINE_ROWS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  sbm_in_if.sink           in_i,
  input  logic [CFG_W-1:0] width_i,
  input  logic [CFG_W-1:0] height_i,
  input  logic [2:0]       window_i,
  input  logic             full_i,
  output logic             push_o,
  output cmd_t             cmd_o
);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int BW = $clog2(LINE_ROWS);

  logic [CW-1:0]      col_q, col_d, c;
  logic [COORD_W-1:0] row_q, row_d, r;
  logic [BW-1:0]      ring_q, ring_d, ring;
  logic [CFG_W-1:0]   w_eff, h_eff;
  logic [2:0]         win, two_h;
  logic [HALF_W-1:0]  half;
  logic               valid;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  // clamp geometry
  always_comb begin
    w_eff = (13'(width_i) > 13'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : width_i;
    h_eff = (13'(height_i) > 13'(ROW_LIMIT)) ? CFG_W'(ROW_LIMIT) : height_i;
    win   = (32'(window_i) > MAX_WINDOW) ? 3'(MAX_WINDOW) : window_i;
    half  = win[2:1];
    two_h = {half, 1'b0};
  end

  // position of this item and edge check
  always_comb begin
    r     = in_i.frame_start ? '0 : row_q;
    c     = in_i.frame_start ? '0 : col_q;
    ring  = in_i.frame_start ? '0 : ring_q;
    valid = (11'(r) >= 11'(two_h)) && (13'(c) >= 13'(half)) &&
            (13'(c) + 13'(half) < 13'(w_eff));
    cmd_o.left_pix  = in_i.left_pixel;
    cmd_o.right_pix = in_i.right_pixel;
    cmd_o.col       = CNT_W'(c);
    cmd_o.width     = CNT_W'(w_eff);
    cmd_o.ring      = RING_W'(ring);
    cmd_o.half      = half;
    cmd_o.valid     = valid;
    cmd_o.out_row   = valid ? r - COORD_W'(two_h) : '0;
    cmd_o.out_col   = valid ? COORD_W'(13'(c) - 13'(half)) : '0;
  end

  // counter advance
  always_comb begin
    col_d  = c + 1'b1;
    row_d  = r;
    ring_d = ring;
    if (13'(c) + 13'd1 >= 13'(w_eff)) begin
      col_d = '0;
      if (11'(r) + 11'd1 >= 11'(h_eff)) begin
        row_d  = '0;
        ring_d = '0;
      end else begin
        row_d  = r + 1'b1;
        ring_d = (ring == BW'(LINE_ROWS-1)) ? '0 : ring + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      ring_q <= '0;
    end else if (push_o) begin
      col_q  <= col_d;
      row_q  <= row_d;
      ring_q <= ring_d;
    end
  end
endmodule

/* rtl/sbm_back.sv */
// back end: line stores and window-parallel ssd search
module sbm_back import sbm_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_WINDOW = DEF_MAX_WINDOW,
  parameter int LINE_ROWS  = DEF_LINE_ROWS
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  logic cmd_valid_i,
  output logic cmd_pop_o,
  output res_t res_o,
  output logic res_valid_o,
  input  logic res_ready_i
);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int BW    = $clog2(LINE_ROWS);
  localparam int TW    = BW + 2;
  localparam int MH    = MAX_WINDOW / 2;
  localparam int NW    = 2 * MH;
  localparam int SQ_W  = 2 * PIX_W;
  localparam int RS_W  = SQ_W + $clog2(NW);
  localparam int TOT_W = RS_W + $clog2(NW);
  localparam int NS    = 5;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN, S_OUT} state_e;

  state_e             state_q;
  cmd_t               cmd_q;
  logic [CW-1:0]      x_q;
  logic [NS-1:0]      pv_q, pl_q;
  logic [CW-1:0]      px_q [NS];
  logic               pf_q;
  logic               have_q;
  logic [TOT_W-1:0]   best_q;
  logic [CNT_W-1:0]   bdisp_q;
  logic               ovalid_q;
  res_t               res_q;

  logic [PIX_W-1:0]   lwin_q [NW][NW];
  logic [PIX_W-1:0]   rwin_q [NW][NW];
  logic [SQ_W-1:0]    sq_q   [NW][NW];
  logic [RS_W-1:0]    rs_q   [NW];
  logic [TOT_W-1:0]   tot_q;

  logic [PIX_W-1:0]   lrd [LINE_ROWS];
  logic [PIX_W-1:0]   rrd [LINE_ROWS];
  logic [BW-1:0]      bank [NW];
  logic [CW-1:0]      l_raddr;
  logic               iss, last_iss;
  logic [2:0]         two_h;
  logic               cand, take;
  logic [CNT_W-1:0]   s_pos, disp;
  logic               out_free;
  res_t               res_d;

  assign two_h       = {cmd_q.half, 1'b0};
  assign cmd_pop_o   = (state_q == S_IDLE) && cmd_valid_i;
  assign iss         = (state_q == S_RUN);
  assign last_iss    = (CNT_W'(x_q) == cmd_q.width - 1'b1);
  assign l_raddr     = cmd_q.col[CW-1:0] - CW'(cmd_q.half) + x_q;
  assign out_free    = !ovalid_q || res_ready_i;
  assign res_o       = res_q;
  assign res_valid_o = ovalid_q;

  // line store banks, one per ring row
  for (genvar b = 0; b < LINE_ROWS; b++) begin : g_bank
    sbm_ram #(.W(PIX_W), .DEPTH(MAX_WIDTH)) u_left (
      .clk_i   (clk_i),
      .we_i    (cmd_pop_o && (cmd_i.ring == RING_W'(b))),
      .waddr_i (cmd_i.col[CW-1:0]),
      .wdata_i (cmd_i.left_pix),
      .raddr_i (l_raddr),
      .rdata_o (lrd[b])
    );
    sbm_ram #(.W(PIX_W), .DEPTH(MAX_WIDTH)) u_right (
      .clk_i   (clk_i),
      .we_i    (cmd_pop_o && (cmd_i.ring == RING_W'(b))),
      .waddr_i (cmd_i.col[CW-1:0]),
      .wdata_i (cmd_i.right_pix),
      .raddr_i (x_q),
      .rdata_o (rrd[b])
    );
  end

  // ring bank of each window row
  always_comb begin
    logic [TW-1:0] t;
    logic [BW-1:0] bb;
    t = TW'(cmd_q.ring) + TW'(2 * LINE_ROWS) - TW'(two_h);
    if (t >= TW'(LINE_ROWS)) t = t - TW'(LINE_ROWS);
    if (t >= TW'(LINE_ROWS)) t = t - TW'(LINE_ROWS);
    bb = BW'(t);
    for (int u = 0; u < NW; u++) begin
      bank[u] = bb;
      bb = (bb == BW'(LINE_ROWS-1)) ? '0 : bb + 1'b1;
    end
  end

  // window shift registers, one column per cycle while pv_q[0] is set; the left window only while pf_q
  always_ff @(posedge clk_i) begin
    if (pv_q[0]) begin
      for (int u = 0; u < NW; u++) begin
        for (int v = 0; v < NW-1; v++) begin
          rwin_q[u][v] <= rwin_q[u][v+1];
          if (pf_q) lwin_q[u][v] <= lwin_q[u][v+1];
        end
        rwin_q[u][NW-1] <= rrd[bank[u]];
        if (pf_q) lwin_q[u][NW-1] <= lrd[bank[u]];
      end
    end
  end

  // squared differences over the active window
  always_ff @(posedge clk_i) begin
    for (int u = 0; u < NW; u++) begin
      for (int v = 0; v < NW; v++) begin
        logic [PIX_W-1:0] dif;
        dif = (lwin_q[u][v] >= rwin_q[u][v]) ? lwin_q[u][v] - rwin_q[u][v]
                                             : rwin_q[u][v] - lwin_q[u][v];
        if ((u < 32'(two_h)) && (v >= NW - 32'(two_h))) begin
          sq_q[u][v] <= SQ_W'(dif) * SQ_W'(dif);
        end else begin
          sq_q[u][v] <= '0;
        end
      end
    end
  end

  // row sums, then total
  always_ff @(posedge clk_i) begin
    logic [TOT_W-1:0] acc;
    for (int u = 0; u < NW; u++) begin
      logic [RS_W-1:0] rs;
      rs = '0;
      for (int v = 0; v < NW; v++) rs = rs + RS_W'(sq_q[u][v]);
      rs_q[u] <= rs;
    end
    acc = '0;
    for (int u = 0; u < NW; u++) acc = acc + TOT_W'(rs_q[u]);
    tot_q <= acc;
  end

  // candidate compare, first minimum wins; the window must end before the last column
  always_comb begin
    cand  = (px_q[NS-1] >= CW'(two_h) - 1'b1) &&
            (CNT_W'(px_q[NS-1]) + 1'b1 < cmd_q.width);
    s_pos = CNT_W'(px_q[NS-1]) - CNT_W'(cmd_q.half) + 1'b1;
    disp  = (s_pos >= cmd_q.col) ? s_pos - cmd_q.col : cmd_q.col - s_pos;
    take  = pv_q[NS-1] && cand && (!have_q || tot_q < best_q);
  end

  // finished result
  always_comb begin
    res_d = '0;
    if (cmd_q.valid) begin
      res_d.valid_res = 1'b1;
      res_d.out_row   = cmd_q.out_row;
      res_d.out_col   = cmd_q.out_col;
      res_d.disparity = (cmd_q.half == '0) ? cmd_q.col[COORD_W-1:0]
                                           : bdisp_q[COORD_W-1:0];
    end
  end

  // sequencer, search pipeline control and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      x_q      <= '0;
      pv_q     <= '0;
      pl_q     <= '0;
      pf_q     <= 1'b0;
      have_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      pv_q  <= {pv_q[NS-2:0], iss};
      pl_q  <= {pl_q[NS-2:0], iss && last_iss};
      pf_q  <= iss && (x_q < CW'(two_h));
      if (take) begin
        have_q <= 1'b1;
      end else if (cmd_pop_o) begin
        have_q <= 1'b0;
      end
      if (state_q == S_OUT && out_free) begin
        ovalid_q <= 1'b1;
      end else if (res_ready_i) begin
        ovalid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            x_q    <= '0;
            state_q <= (cmd_i.valid && cmd_i.half != '0) ? S_RUN : S_OUT;
          end
        end
        S_RUN: begin
          x_q <= x_q + 1'b1;
          if (last_iss) state_q <= S_DRAIN;
        end
        S_DRAIN: begin
          if (pv_q[NS-1] && pl_q[NS-1]) state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) cmd_q <= cmd_i;
    px_q[0] <= x_q;
    for (int k = 1; k < NS; k++) px_q[k] <= px_q[k-1];
    if (take) begin
      best_q  <= tot_q;
      bdisp_q <= disp;
    end
    if (state_q == S_OUT && out_free) res_q <= res_d;
  end

  // checks
  a_run_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) |-> (cmd_q.valid && cmd_q.half != '0))
    else $error("search started for an edge item");
  a_drain_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pv_q[NS-1] && pl_q[NS-1]) |-> (state_q == S_DRAIN))
    else $error("last candidate outside drain");
  a_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && cmd_q.valid && cmd_q.half != '0) |-> have_q)
    else $error("no candidate found for a valid item");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> (state_q == S_RUN || state_q == S_OUT))
    else $error("pop did not start an item");
endmodule

/* rtl/ssd_stereo_block_matcher_top.sv */
// Stereo block matcher: takes left/right grey pixel pairs in raster order and returns one
// disparity item per pixel, the first minimum of the sum of squared differences over a
// window of rows r-2*half..r-1, searched over every column of the row where the window
// fits. Items are queued by the front (two deep); the back takes one at a time. An edge
// item (or one with half zero) is not searched; for a searched item the right line store
// is read one column per cycle while the whole window is compared in parallel. Line
// stores are not cleared after reset and need no pass.
module ssd_stereo_block_matcher_top import sbm_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_WINDOW = DEF_MAX_WINDOW,
  parameter int LINE_ROWS  = DEF_LINE_ROWS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  sbm_in_if.sink           in_i,
  sbm_out_if.source        out_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i
);
  logic [CFG_W-1:0] width_q, height_q;
  logic [2:0]       window_q;
  logic             push, full, pop, empty;
  cmd_t             cmd_in, cmd_out;
  res_t             res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_WIDTH;
      height_q <= RST_HEIGHT;
      window_q <= RST_WINDOW;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        CFG_WINDOW: window_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  sbm_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_WINDOW(MAX_WINDOW), .LINE_ROWS(LINE_ROWS)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .width_i  (width_q),
    .height_i (height_q),
    .window_i (window_q),
    .full_i   (full),
    .push_o   (push),
    .cmd_o    (cmd_in)
  );

  sbm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (cmd_out),
    .empty_o (empty)
  );

  sbm_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_WINDOW(MAX_WINDOW), .LINE_ROWS(LINE_ROWS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_out),
    .cmd_valid_i (!empty),
    .cmd_pop_o   (pop),
    .res_o       (res),
    .res_valid_o (out_o.valid),
    .res_ready_i (out_o.ready)
  );

  // result fields
  assign out_o.valid_res = res.valid_res;
  assign out_o.out_row   = res.out_row;
  assign out_o.out_col   = res.out_col;
  assign out_o.disparity = res.disparity;
endmodule
